[hw/rtl/pixel_format_to_bgra32_unit_defines.svh]
// Assertion macros for the BGRA32 pixel converter.
// Needs clk and rst_n in the scope of the including module.
`ifndef PIXEL_FORMAT_TO_BGRA32_UNIT_DEFINES_SVH
`define PIXEL_FORMAT_TO_BGRA32_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PFB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define PFB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[hw/rtl/pfb_pkg.sv]
// Shared types and constants of the BGRA32 pixel converter.
// No dependencies.
package pfb_pkg;

  typedef enum logic [2:0] {
    FMT_RGB24    = 3'd0,
    FMT_RGBA32   = 3'd1,
    FMT_BGR24    = 3'd2,
    FMT_BGRA32   = 3'd3,
    FMT_GRAY8    = 3'd4,
    FMT_INDEXED8 = 3'd5,
    FMT_INDEXED1 = 3'd6,
    FMT_OTHER    = 3'd7
  } fmt_e;

  localparam logic OP_CONVERT   = 1'b0;
  localparam logic OP_PAL_WRITE = 1'b1;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 9;

  localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_FORMAT   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_ENTRIES = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [2:0] BIT_MSB      = 3'd7;
  localparam int unsigned ADDR_W      = 8;

  // Packed so that bits 7:0 are blue, as in a palette word.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [31:0]       wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } ram_req_t;

endpackage

[hw/rtl/pfb_in_if.sv]
// Input request channel of the BGRA32 pixel converter.
// No dependencies.
interface pfb_in_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [7:0]  src_byte0;
  logic [7:0]  src_byte1;
  logic [7:0]  src_byte2;
  logic [7:0]  src_byte3;
  logic [2:0]  bit_position;
  logic [7:0]  entry_index;
  logic [31:0] entry_value;

  modport source (
    output valid, operation, src_byte0, src_byte1, src_byte2, src_byte3,
           bit_position, entry_index, entry_value,
    input  ready
  );
  modport sink (
    input  valid, operation, src_byte0, src_byte1, src_byte2, src_byte3,
           bit_position, entry_index, entry_value,
    output ready
  );
endinterface

[hw/rtl/pfb_out_if.sv]
// Result channel of the BGRA32 pixel converter.
// No dependencies.
interface pfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic [7:0] out_alpha;

  modport source (
    output valid, out_blue, out_green, out_red, out_alpha,
    input  ready
  );
  modport sink (
    input  valid, out_blue, out_green, out_red, out_alpha,
    output ready
  );
endinterface

[hw/rtl/pfb_palette_ram.sv]
// Palette memory: one write and one registered read per cycle.
// Depends on pfb_pkg.
module pfb_palette_ram #(
  parameter int unsigned DEPTH = 256
) (
  input  logic              clk,
  input  pfb_pkg::ram_req_t req,
  output logic [31:0]       rd_data
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [31:0] mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr[AW-1:0]] <= req.wr_data;
    end
  end

  // Hold the read word until the next read.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr[AW-1:0]];
    end
  end

  assign rd_data = rd_data_r;
endmodule

[hw/rtl/pixel_format_to_bgra32_unit.sv]
// Pixel converter top level: source formats and palette to BGRA32.
// Depends on pfb_pkg, pfb_in_if, pfb_out_if, pfb_palette_ram and the defines header.
//
// Use: each request on in_ch either converts one source pixel (operation 0)
// or writes one palette word (operation 1). A conversion gives one result on
// out_ch; a palette write gives none. Configuration goes through the cfg_
// write port: index 0 source format, index 1 palette entry count. Write it
// only while no request is in flight.
// Pipeline: an accepted request passes through the palette read stage and
// then the output register.
// Throughput: one request per cycle while out_ch does not stall; the palette
// RAM takes one write and one read each cycle, so a palette write followed at
// once by a lookup of the same entry already reads the new word.
// Reset (synchronous, active low): source format BGRA32, palette count zero,
// both pipeline stages empty. The palette contents are not cleared; an
// entry must be written before a lookup may hit it.
// Receiver stall: the output register holds, the read stage holds its
// request and the palette word behind it, and in_ch.ready drops once both
// stages are full.
`include "pixel_format_to_bgra32_unit_defines.svh"

module pixel_format_to_bgra32_unit #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  pfb_in_if.sink                              in_ch,
  pfb_out_if.source                           out_ch,
  input  logic                                cfg_we,
  input  logic [pfb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

  // Configuration registers.
  pfb_pkg::fmt_e source_format_r;
  logic [8:0]    palette_entries_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r   <= pfb_pkg::FMT_BGRA32;
      palette_entries_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pfb_pkg::REG_SOURCE_FORMAT: begin
          source_format_r <= pfb_pkg::fmt_e'(cfg_wdata[2:0]);
        end
        pfb_pkg::REG_PALETTE_ENTRIES: begin
          palette_entries_r <= cfg_wdata[8:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Handshake and stage control.
  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s1_adv, acc, acc_conv, acc_write;

  assign s1_adv      = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign acc         = in_ch.valid && in_ch.ready;
  assign acc_conv    = acc && (in_ch.operation == pfb_pkg::OP_CONVERT);
  assign acc_write   = acc && (in_ch.operation == pfb_pkg::OP_PAL_WRITE);

  // Front end: direct swizzle, palette index and range check.
  pfb_pkg::pix_t direct_pix;
  logic          use_pal;
  logic [7:0]    pal_idx;
  logic [8:0]    pal_count;
  logic          pal_hit;

  always_comb begin
    direct_pix = '{alpha: pfb_pkg::ALPHA_OPAQUE, red: pfb_pkg::ALPHA_OPAQUE,
                   green: pfb_pkg::ALPHA_OPAQUE, blue: pfb_pkg::ALPHA_OPAQUE};
    use_pal    = 1'b0;
    pal_idx    = in_ch.src_byte0;
    case (source_format_r)
      pfb_pkg::FMT_RGB24: begin
        direct_pix = '{alpha: pfb_pkg::ALPHA_OPAQUE, red: in_ch.src_byte0,
                       green: in_ch.src_byte1, blue: in_ch.src_byte2};
      end
      pfb_pkg::FMT_RGBA32: begin
        direct_pix = '{alpha: in_ch.src_byte3, red: in_ch.src_byte0,
                       green: in_ch.src_byte1, blue: in_ch.src_byte2};
      end
      pfb_pkg::FMT_BGR24: begin
        direct_pix = '{alpha: pfb_pkg::ALPHA_OPAQUE, red: in_ch.src_byte2,
                       green: in_ch.src_byte1, blue: in_ch.src_byte0};
      end
      pfb_pkg::FMT_BGRA32: begin
        direct_pix = '{alpha: in_ch.src_byte3, red: in_ch.src_byte2,
                       green: in_ch.src_byte1, blue: in_ch.src_byte0};
      end
      pfb_pkg::FMT_GRAY8: begin
        direct_pix = '{alpha: pfb_pkg::ALPHA_OPAQUE, red: in_ch.src_byte0,
                       green: in_ch.src_byte0, blue: in_ch.src_byte0};
      end
      pfb_pkg::FMT_INDEXED8: begin
        use_pal = 1'b1;
      end
      pfb_pkg::FMT_INDEXED1: begin
        use_pal = 1'b1;
        // Leftmost pixel sits in the most significant bit.
        pal_idx = {7'd0, in_ch.src_byte0[pfb_pkg::BIT_MSB - in_ch.bit_position]};
      end
      default: begin
        // Unknown formats come out opaque white.
      end
    endcase
  end

  // Clamp an oversized count to the palette depth; a zero count never hits.
  assign pal_count = (palette_entries_r > DEPTH_W) ? DEPTH_W : palette_entries_r;
  assign pal_hit   = ({1'b0, pal_idx} < pal_count);

  // Palette RAM access.
  pfb_pkg::ram_req_t ram_req;
  logic [31:0]       ram_rd_data;

  always_comb begin
    ram_req.wr_en   = acc_write && ({1'b0, in_ch.entry_index} < DEPTH_W);
    ram_req.wr_addr = in_ch.entry_index;
    ram_req.wr_data = in_ch.entry_value;
    ram_req.rd_en   = acc_conv && use_pal && pal_hit;
    ram_req.rd_addr = pal_idx;
  end

  pfb_palette_ram #(
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk     (clk),
    .req     (ram_req),
    .rd_data (ram_rd_data)
  );

  // Read stage: holds a conversion while its palette word comes out of the RAM.
  pfb_pkg::pix_t s1_pix_r;
  logic          s1_use_pal_r;
  logic          s1_hit_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc) begin
      s1_valid_nxt = acc_conv;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_conv) begin
      s1_pix_r     <= direct_pix;
      s1_use_pal_r <= use_pal;
      s1_hit_r     <= pal_hit;
    end
  end

  // Output register.
  pfb_pkg::pix_t out_pix_r;
  pfb_pkg::pix_t s1_result;

  // A miss in an indexed mode gives all zeros.
  assign s1_result = !s1_use_pal_r ? s1_pix_r :
                     (s1_hit_r ? pfb_pkg::pix_t'(ram_rd_data) : '0);

  assign out_valid_nxt = s1_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_pix_r <= s1_result;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_blue  = out_pix_r.blue;
  assign out_ch.out_green = out_pix_r.green;
  assign out_ch.out_red   = out_pix_r.red;
  assign out_ch.out_alpha = out_pix_r.alpha;

  // Checks.
  // A stalled lookup that actually read the palette.
  logic s1_pal_stall;
  assign s1_pal_stall = s1_valid_r && s1_use_pal_r && s1_hit_r && !s1_adv;

  `PFB_ASSERT_NEXT(a_write_no_result, acc_write, !s1_valid_r)
  `PFB_ASSERT_NEXT(a_conv_enters_s1, acc_conv, s1_valid_r)
  `PFB_ASSERT_NEXT(a_rd_word_held, s1_pal_stall, s1_valid_r && $stable(ram_rd_data))
  `PFB_ASSERT_NOW(a_no_read_on_write, ram_req.wr_en, !ram_req.rd_en)

endmodule

[test/pixel_format_to_bgra32_unit_test.sv]
// Self-checking bench for the BGRA32 pixel converter: conversions in every source
// format, palette writes and lookups, checked against an in-bench predictor.
// Depends on pfb_pkg, pfb_in_if, pfb_out_if and pixel_format_to_bgra32_unit.
module pixel_format_to_bgra32_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PAL_DEPTH = 256;

  // One request on the input channel, every field at its port width.
  typedef struct packed {
    logic        op;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [7:0]  byte3;
    logic [2:0]  pos;
    logic [7:0]  entry;
    logic [31:0] colour;
  } pixel_request_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [pfb_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [pfb_pkg::CFG_DATA_W-1:0]  cfg_wdata;

  pfb_in_if  in_ch ();
  pfb_out_if out_ch ();

  pixel_format_to_bgra32_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the block: configuration and palette contents.
  pfb_pkg::fmt_e cur_format = pfb_pkg::FMT_BGRA32;
  logic [8:0]    pal_count  = '0;
  logic [31:0]   pal_model [PAL_DEPTH];

  // Stimulus side bookkeeping: which palette entries will have been written
  // by the time each queued request reaches the block.
  bit gen_written [PAL_DEPTH];

  pixel_request_t pending_reqs [$];
  pfb_pkg::pix_t  expected_pixels [$];

  int issued_count   = 0;
  int accepted_count = 0;
  int results_seen   = 0;
  int error_count    = 0;
  int idle_pct       = 0;
  int src_gap_left   = 0;
  int sink_gap_left  = 0;
  bit hold_output    = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Entry count as the block applies it: anything above the depth saturates.
  function automatic int effective_entries();
    return (pal_count > PAL_DEPTH) ? PAL_DEPTH : int'(pal_count);
  endfunction

  function automatic pfb_pkg::pix_t palette_pixel(logic [7:0] idx);
    // Out-of-range index or an empty palette gives transparent black
    if (int'(idx) >= effective_entries()) return '0;
    return pfb_pkg::pix_t'(pal_model[idx]);
  endfunction

  // Expected BGRA32 pixel for one conversion request under the current setup.
  function automatic pfb_pkg::pix_t bgra_of(pixel_request_t r);
    case (cur_format)
      pfb_pkg::FMT_RGB24:    return {pfb_pkg::ALPHA_OPAQUE, r.byte0, r.byte1, r.byte2};
      pfb_pkg::FMT_RGBA32:   return {r.byte3, r.byte0, r.byte1, r.byte2};
      pfb_pkg::FMT_BGR24:    return {pfb_pkg::ALPHA_OPAQUE, r.byte2, r.byte1, r.byte0};
      pfb_pkg::FMT_BGRA32:   return {r.byte3, r.byte2, r.byte1, r.byte0};
      pfb_pkg::FMT_GRAY8:    return {pfb_pkg::ALPHA_OPAQUE, r.byte0, r.byte0, r.byte0};
      pfb_pkg::FMT_INDEXED8: return palette_pixel(r.byte0);
      pfb_pkg::FMT_INDEXED1: return palette_pixel({7'd0, r.byte0[pfb_pkg::BIT_MSB - r.pos]});
      default:               return '1;  // opaque white for unsupported formats
    endcase
  endfunction

  function automatic pixel_request_t random_request(logic op);
    pixel_request_t r;
    r.op     = op;
    r.byte0  = 8'($urandom);
    r.byte1  = 8'($urandom);
    r.byte2  = 8'($urandom);
    r.byte3  = 8'($urandom);
    r.pos    = 3'($urandom);
    r.entry  = 8'($urandom);
    r.colour = $urandom;
    return r;
  endfunction

  function automatic pixel_request_t make_convert(logic [31:0] bytes, logic [2:0] pos);
    pixel_request_t r;
    r = random_request(pfb_pkg::OP_CONVERT);
    {r.byte3, r.byte2, r.byte1, r.byte0} = bytes;
    r.pos = pos;
    return r;
  endfunction

  function automatic pixel_request_t make_write(logic [7:0] entry, logic [31:0] colour);
    pixel_request_t r;
    r = random_request(pfb_pkg::OP_PAL_WRITE);
    r.entry  = entry;
    r.colour = colour;
    return r;
  endfunction

  // Queue a request. A lookup that would land on an entry inside the count
  // that nobody has written yet gets a palette write in front of it.
  function automatic void queue_request(pixel_request_t r);
    logic [7:0] idx;
    if (r.op == pfb_pkg::OP_PAL_WRITE) begin
      gen_written[r.entry] = 1'b1;
    end else if (cur_format == pfb_pkg::FMT_INDEXED8 ||
                 cur_format == pfb_pkg::FMT_INDEXED1) begin
      idx = (cur_format == pfb_pkg::FMT_INDEXED8) ? r.byte0 :
            {7'd0, r.byte0[pfb_pkg::BIT_MSB - r.pos]};
      if (int'(idx) < effective_entries() && !gen_written[idx]) begin
        pending_reqs = {pending_reqs, make_write(idx, $urandom)};
        gen_written[idx] = 1'b1;
      end
    end
    pending_reqs = {pending_reqs, r};
  endfunction

  // Random request shaped for the current format: lookups mostly hit the
  // valid range, palette writes are more frequent in the indexed modes.
  function automatic void queue_random_request();
    pixel_request_t r;
    int lim;
    int write_pct;
    lim = effective_entries();
    write_pct = (cur_format == pfb_pkg::FMT_INDEXED8 ||
                 cur_format == pfb_pkg::FMT_INDEXED1) ? 25 : 10;
    r = random_request(($urandom_range(0, 99) < write_pct) ? pfb_pkg::OP_PAL_WRITE
                                                           : pfb_pkg::OP_CONVERT);
    if (lim != 0 && $urandom_range(0, 1) == 1) r.entry = 8'($urandom_range(0, lim - 1));
    if (cur_format == pfb_pkg::FMT_INDEXED8 && lim != 0 && $urandom_range(0, 3) != 0)
      r.byte0 = 8'($urandom_range(0, lim - 1));
    queue_request(r);
  endfunction

  // Wait until every queued request has gone in and every pixel is back.
  task automatic wait_for_quiet();
    while (pending_reqs.size() != 0 || issued_count != accepted_count ||
           expected_pixels.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [pfb_pkg::CFG_INDEX_W-1:0] idx,
                                logic [pfb_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == pfb_pkg::REG_SOURCE_FORMAT) cur_format = pfb_pkg::fmt_e'(data[2:0]);
    else                                   pal_count  = data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Reconfigure only once the block has gone quiet.
  task automatic start_phase(pfb_pkg::fmt_e fmt, logic [8:0] count);
    wait_for_quiet();
    write_register(pfb_pkg::REG_SOURCE_FORMAT, pfb_pkg::CFG_DATA_W'(fmt));
    write_register(pfb_pkg::REG_PALETTE_ENTRIES, count);
  endtask

  // Request driver: advance on the falling edge once the current request has
  // been taken, inserting random idle bursts while work is pending.
  always @(negedge clk) begin
    pixel_request_t r;
    if (!in_ch.valid || issued_count == accepted_count) begin
      if (src_gap_left != 0) begin
        in_ch.valid <= 1'b0;
        src_gap_left--;
      end else if (pending_reqs.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
        in_ch.valid  <= 1'b0;
        src_gap_left = $urandom_range(0, 9);
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        in_ch.operation    <= r.op;
        in_ch.src_byte0    <= r.byte0;
        in_ch.src_byte1    <= r.byte1;
        in_ch.src_byte2    <= r.byte2;
        in_ch.src_byte3    <= r.byte3;
        in_ch.bit_position <= r.pos;
        in_ch.entry_index  <= r.entry;
        in_ch.entry_value  <= r.colour;
        in_ch.valid        <= 1'b1;
        issued_count++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random back-pressure bursts, plus the long hold-off.
  always @(negedge clk) begin
    if (hold_output) begin
      out_ch.ready <= 1'b0;
    end else if (sink_gap_left != 0) begin
      out_ch.ready <= 1'b0;
      sink_gap_left--;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      out_ch.ready  <= 1'b0;
      sink_gap_left = $urandom_range(0, 9);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Hold the receiver off for a long stretch in mid-run, once plenty of
  // requests are queued so the driver keeps offering them, so both pipeline
  // stages fill and in_ch.ready drops.
  initial begin
    while (results_seen < 300 || pending_reqs.size() < 20) @(posedge clk);
    hold_output = 1'b1;
    repeat (120) @(posedge clk);
    hold_output = 1'b0;
  end

  // Monitor: check results first, then feed accepted requests to the predictor.
  always @(posedge clk) begin
    pixel_request_t r;
    pfb_pkg::pix_t got;
    pfb_pkg::pix_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_alpha, out_ch.out_red, out_ch.out_green, out_ch.out_blue};
        results_seen++;
        if (expected_pixels.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: unexpected pixel a=%02h r=%02h g=%02h b=%02h",
                     $realtime, got.alpha, got.red, got.green, got.blue);
        end else begin
          want = expected_pixels.pop_front();
          if (got.blue !== want.blue || got.green !== want.green ||
              got.red !== want.red || got.alpha !== want.alpha) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: pixel mismatch expected a=%02h r=%02h g=%02h b=%02h, %s",
                       $realtime, want.alpha, want.red, want.green, want.blue,
                       $sformatf("got a=%02h r=%02h g=%02h b=%02h",
                                 got.alpha, got.red, got.green, got.blue));
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        accepted_count++;
        r = {in_ch.operation, in_ch.src_byte0, in_ch.src_byte1, in_ch.src_byte2,
             in_ch.src_byte3, in_ch.bit_position, in_ch.entry_index, in_ch.entry_value};
        if (r.op == pfb_pkg::OP_PAL_WRITE) pal_model[r.entry] = r.colour;
        else                               expected_pixels = {expected_pixels, bgra_of(r)};
      end
    end
  end

  // Main sequence: reset, directed checks, random phases, calm tail.
  initial begin
    pfb_pkg::fmt_e fmt;
    logic [8:0] count;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.operation    = pfb_pkg::OP_CONVERT;
    in_ch.src_byte0    = '0;
    in_ch.src_byte1    = '0;
    in_ch.src_byte2    = '0;
    in_ch.src_byte3    = '0;
    in_ch.bit_position = '0;
    in_ch.entry_index  = '0;
    in_ch.entry_value  = '0;
    out_ch.ready       = 1'b0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // Reset configuration is BGRA32 pass-through: all-zero, all-one, mixed
    idle_pct = 20;
    queue_request(make_convert(32'h0000_0000, 3'd0));
    queue_request(make_convert(32'hFFFF_FFFF, 3'd7));
    queue_request(make_convert(32'h7856_3412, 3'd3));

    // Byte orders, grey expansion and the unsupported format
    start_phase(pfb_pkg::FMT_RGB24, 9'd0);
    queue_request(make_convert(32'h8003_0201, 3'd0));
    start_phase(pfb_pkg::FMT_RGBA32, 9'd0);
    queue_request(make_convert(32'hD4C3_B2A1, 3'd0));
    start_phase(pfb_pkg::FMT_BGR24, 9'd0);
    queue_request(make_convert(32'hD4C3_B2A1, 3'd0));
    start_phase(pfb_pkg::FMT_GRAY8, 9'd0);
    queue_request(make_convert(32'h0000_00FF, 3'd0));
    queue_request(make_convert(32'hFFFF_FF5A, 3'd0));
    start_phase(pfb_pkg::FMT_OTHER, 9'd0);
    queue_request(make_convert($urandom, 3'd0));

    // Palette writes with an empty palette: every lookup misses
    start_phase(pfb_pkg::FMT_INDEXED8, 9'd0);
    queue_request(make_write(8'd0, 32'h0000_0000));
    queue_request(make_write(8'd1, 32'hFFFF_FFFF));
    queue_request(make_write(8'd255, $urandom));
    queue_request(make_convert(32'h0000_0000, 3'd0));

    // Full palette: first, second and last entries
    start_phase(pfb_pkg::FMT_INDEXED8, 9'd256);
    queue_request(make_convert(32'h0000_0000, 3'd0));
    queue_request(make_convert(32'h0000_0001, 3'd0));
    queue_request(make_convert(32'h0000_00FF, 3'd0));

    // Two entries: hit, miss just past the count, write then immediate read
    start_phase(pfb_pkg::FMT_INDEXED8, 9'd2);
    queue_request(make_convert(32'h0000_0001, 3'd0));
    queue_request(make_convert(32'h0000_0002, 3'd0));
    queue_request(make_write(8'd1, $urandom));
    queue_request(make_convert(32'h0000_0001, 3'd0));

    // One-bit indexing: MSB at position 0, LSB at position 7
    start_phase(pfb_pkg::FMT_INDEXED1, 9'd2);
    queue_request(make_convert(32'h0000_0080, 3'd0));
    queue_request(make_convert(32'h0000_0080, 3'd7));
    queue_request(make_convert(32'h0000_0001, 3'd7));
    start_phase(pfb_pkg::FMT_INDEXED1, 9'd1);
    queue_request(make_convert(32'h0000_00FF, 3'd3));

    // Oversized entry count behaves as a full palette
    start_phase(pfb_pkg::FMT_INDEXED8, 9'd511);
    queue_request(make_convert(32'h0000_00FF, 3'd0));

    // Random phases: every format once, then random formats and counts
    for (int p = 0; p < 20; p++) begin
      fmt = (p < 8) ? pfb_pkg::fmt_e'(p) : pfb_pkg::fmt_e'($urandom_range(0, 7));
      case ($urandom_range(0, 6))
        0:       count = 9'd0;
        1:       count = 9'd1;
        2:       count = 9'd2;
        3:       count = 9'd256;
        4:       count = 9'($urandom_range(257, 511));
        default: count = 9'($urandom_range(3, 255));
      endcase
      start_phase(fmt, count);
      case ($urandom_range(0, 2))
        0:       idle_pct = 0;
        1:       idle_pct = 10;
        default: idle_pct = 35;
      endcase
      for (int i = 0; i < 55; i++) queue_random_request();
    end

    // Calm tail: no idling on either side
    idle_pct = 0;
    start_phase(pfb_pkg::fmt_e'($urandom_range(0, 7)), 9'($urandom_range(0, 511)));
    for (int i = 0; i < 150; i++) queue_random_request();

    wait_for_quiet();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
